[src/dpbb_pkg.sv]
// Shared types and constants for the decoded picture buffer bumping unit.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package dpbb_pkg;

  localparam int unsigned LAT_MAX = 255;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_ORDER_BY_POC = 3'd0;
  localparam logic [2:0] REG_TWO_FIELDS   = 3'd1;
  localparam logic [2:0] REG_MAX_PICS     = 3'd2;
  localparam logic [2:0] REG_MAX_REORDER  = 3'd3;
  localparam logic [2:0] REG_MAX_LATENCY  = 3'd4;

  // Entry flag bit positions.
  localparam int unsigned FLAG_FIELD = 0;
  localparam int unsigned FLAG_WANT  = 1;
  localparam int unsigned FLAG_PIC   = 2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LAT,
    S_DISCARD,
    S_SCAN,
    S_EMPTY,
    S_BUMP,
    S_SEARCH,
    S_FINISH
  } state_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LATCH,
    OP_LAT_UPD,
    OP_REMOVE,
    OP_INSERT,
    OP_EMIT_NEW,
    OP_FLUSH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   at_idx;
    logic   drop;
    logic   idx_clr;
    logic   idx_inc;
  } cmd_t;

  typedef struct packed {
    logic drain;
    logic kf_clear;
    logic discard;
    logic count_zero;
    logic full;
    logic bump;
    logic idx_at_count;
    logic idx_want;
    logic ins_cond;
  } status_t;

  typedef struct packed {
    logic       order_by_poc;
    logic       two_fields_per_slot;
    logic [4:0] max_pictures_buffered;
    logic [4:0] max_reorder_count;
    logic [7:0] max_latency_count;
  } cfg_t;

endpackage

[src/dpbb_ctrl.sv]
// Controller state machine of the decoded picture buffer bumping unit.
// Depends on dpbb_pkg; drives commands to dpbb_datapath and reads its status.
`timescale 1ns / 1ps

module dpbb_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  dpbb_pkg::status_t st,
  output dpbb_pkg::cmd_t    cmd
);

  dpbb_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dpbb_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd.op      = dpbb_pkg::OP_NOP;
    cmd.at_idx  = 1'b0;
    cmd.drop    = 1'b0;
    cmd.idx_clr = 1'b0;
    cmd.idx_inc = 1'b0;
    busy        = 1'b1;
    unique case (state)
      dpbb_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.op      = dpbb_pkg::OP_LATCH;
          cmd.idx_clr = 1'b1;
          state_next  = dpbb_pkg::S_LAT;
        end
      end
      dpbb_pkg::S_LAT: begin
        if (st.drain) begin
          state_next = dpbb_pkg::S_EMPTY;
        end else begin
          cmd.op = dpbb_pkg::OP_LAT_UPD;
          if (st.kf_clear) begin
            state_next = st.discard ? dpbb_pkg::S_DISCARD : dpbb_pkg::S_SCAN;
          end else begin
            state_next = dpbb_pkg::S_BUMP;
          end
        end
      end
      dpbb_pkg::S_DISCARD: begin
        if (!st.count_zero) begin
          cmd.op   = dpbb_pkg::OP_REMOVE;
          cmd.drop = 1'b1;
        end else begin
          state_next = dpbb_pkg::S_EMPTY;
        end
      end
      dpbb_pkg::S_SCAN: begin
        // Entries that do not want output leave in place; the index holds.
        if (st.idx_at_count) begin
          state_next = dpbb_pkg::S_EMPTY;
        end else if (!st.idx_want) begin
          cmd.op     = dpbb_pkg::OP_REMOVE;
          cmd.at_idx = 1'b1;
          cmd.drop   = 1'b1;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      dpbb_pkg::S_EMPTY: begin
        if (!st.count_zero) begin
          cmd.op = dpbb_pkg::OP_REMOVE;
        end else if (st.drain) begin
          state_next = dpbb_pkg::S_FINISH;
        end else begin
          state_next = dpbb_pkg::S_BUMP;
        end
      end
      dpbb_pkg::S_BUMP: begin
        if (!st.count_zero && st.bump) begin
          cmd.op = dpbb_pkg::OP_REMOVE;
        end else if (st.full) begin
          cmd.op     = dpbb_pkg::OP_EMIT_NEW;
          state_next = dpbb_pkg::S_FINISH;
        end else begin
          cmd.idx_clr = 1'b1;
          state_next  = dpbb_pkg::S_SEARCH;
        end
      end
      dpbb_pkg::S_SEARCH: begin
        if (st.idx_at_count || st.ins_cond) begin
          cmd.op     = dpbb_pkg::OP_INSERT;
          state_next = dpbb_pkg::S_FINISH;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      dpbb_pkg::S_FINISH: begin
        cmd.op     = dpbb_pkg::OP_FLUSH;
        state_next = dpbb_pkg::S_IDLE;
      end
      default: begin
        state_next = dpbb_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[src/dpbb_datapath.sv]
// Datapath of the decoded picture buffer bumping unit: entry table, counters,
// one-deep result hold. Depends on dpbb_pkg; commanded by dpbb_ctrl.
`timescale 1ns / 1ps

module dpbb_datapath #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  dpbb_pkg::cfg_t     cfg,
  input  dpbb_pkg::cmd_t     cmd,
  output dpbb_pkg::status_t  st,
  input  logic               kind,
  input  logic signed [31:0] order_count,
  input  logic signed [63:0] present_time,
  input  logic               is_single_field,
  input  logic               wants_output,
  input  logic               has_picture,
  input  logic [15:0]        picture_tag,
  input  logic               no_leading_output,
  input  logic               is_keyframe,
  input  logic               discard_prior,
  input  logic               flush_now,
  output logic               out_valid,
  output logic [15:0]        out_tag,
  output logic signed [63:0] out_time,
  output logic               dropped,
  output logic               last
);

  localparam int unsigned CW  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned IW  = $clog2(MAX_ENTRIES);
  localparam int unsigned SFW = $clog2(2 * MAX_ENTRIES + 2);

  logic signed [31:0] e_order [MAX_ENTRIES];
  logic signed [63:0] e_time  [MAX_ENTRIES];
  logic [2:0]         e_flags [MAX_ENTRIES];
  logic [15:0]        e_tag   [MAX_ENTRIES];
  logic [7:0]         e_lat   [MAX_ENTRIES];

  logic               in_kind, in_kf_clear, in_discard, in_flush;
  logic signed [31:0] in_order;
  logic signed [63:0] in_time;
  logic [2:0]         in_flags;
  logic [15:0]        in_tag;

  logic [CW-1:0]  count, occ, waiting, idx;
  logic [SFW-1:0] sfields;

  logic               pend_v, pend_drop;
  logic [15:0]        pend_tag;
  logic signed [63:0] pend_time;

  logic [CW-1:0]      rm_at;
  logic [IW-1:0]      rm_sel, idx_sel;
  logic [2:0]         rm_flags;
  logic [SFW-1:0]     rm_fields, sf_dec, sf_inc, in_fields;
  logic [SFW-1:0]     sf_dec_r, sf_inc_r;
  logic               cand_v, cand_drop;
  logic [15:0]        cand_tag;
  logic signed [63:0] cand_time;
  logic [MAX_ENTRIES-1:0] lat_hit_vec;
  logic               lat_hit;

  assign rm_at     = cmd.at_idx ? idx : '0;
  assign rm_sel    = rm_at[IW-1:0];
  assign idx_sel   = idx[IW-1:0];
  assign rm_flags  = e_flags[rm_sel];
  assign rm_fields = rm_flags[dpbb_pkg::FLAG_FIELD] ? SFW'(1) : SFW'(2);
  assign in_fields = in_flags[dpbb_pkg::FLAG_FIELD] ? SFW'(1) : SFW'(2);
  assign sf_dec    = (sfields >= rm_fields) ? sfields - rm_fields : '0;
  assign sf_inc    = sfields + in_fields;
  assign sf_dec_r  = (sf_dec + SFW'(1)) >> 1;
  assign sf_inc_r  = (sf_inc + SFW'(1)) >> 1;

  always_comb begin
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      lat_hit_vec[k] = (CW'(k) < count) && e_flags[k][dpbb_pkg::FLAG_WANT]
                       && (e_lat[k] >= cfg.max_latency_count);
    end
  end
  assign lat_hit = |lat_hit_vec;

  always_comb begin
    st.drain        = in_kind;
    st.kf_clear     = in_kf_clear;
    st.discard      = in_discard;
    st.count_zero   = (count == '0);
    st.full         = (count == CW'(MAX_ENTRIES));
    st.bump         = in_flush
                   || (8'(occ) >= 8'(cfg.max_pictures_buffered))
                   || ((cfg.max_reorder_count != '0)
                       && (8'(waiting) > 8'(cfg.max_reorder_count)))
                   || ((cfg.max_latency_count != '0) && (waiting != '0) && lat_hit);
    st.idx_at_count = (idx == count);
    st.idx_want     = e_flags[idx_sel][dpbb_pkg::FLAG_WANT];
    st.ins_cond     = cfg.order_by_poc ? (e_order[idx_sel] > in_order)
                                       : (e_time[idx_sel] >= in_time);
  end

  always_comb begin
    cand_v    = 1'b0;
    cand_tag  = e_tag[rm_sel];
    cand_time = e_time[rm_sel];
    cand_drop = cmd.drop;
    if (cmd.op == dpbb_pkg::OP_REMOVE) begin
      cand_v = rm_flags[dpbb_pkg::FLAG_PIC];
    end else if (cmd.op == dpbb_pkg::OP_EMIT_NEW) begin
      cand_v    = in_flags[dpbb_pkg::FLAG_PIC];
      cand_tag  = in_tag;
      cand_time = in_time;
      cand_drop = 1'b1;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      occ       <= '0;
      waiting   <= '0;
      sfields   <= '0;
      idx       <= '0;
      pend_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + CW'(1);
      end
      if (cmd.op == dpbb_pkg::OP_REMOVE) begin
        count   <= count - CW'(1);
        sfields <= sf_dec;
        if (cfg.two_fields_per_slot) begin
          occ <= sf_dec_r[CW-1:0];
        end else if (occ != '0) begin
          occ <= occ - CW'(1);
        end
        if (rm_flags[dpbb_pkg::FLAG_WANT] && waiting != '0) begin
          waiting <= waiting - CW'(1);
        end
      end else if (cmd.op == dpbb_pkg::OP_INSERT) begin
        count   <= count + CW'(1);
        sfields <= sf_inc;
        occ     <= cfg.two_fields_per_slot ? sf_inc_r[CW-1:0] : occ + CW'(1);
        if (in_flags[dpbb_pkg::FLAG_WANT]) begin
          waiting <= waiting + CW'(1);
        end
      end
      // A result goes out only once the next one, or the end, is known.
      out_valid <= 1'b0;
      if (cand_v) begin
        pend_v <= 1'b1;
        if (pend_v) begin
          out_valid <= 1'b1;
        end
      end else if (cmd.op == dpbb_pkg::OP_FLUSH) begin
        pend_v <= 1'b0;
        if (pend_v) begin
          out_valid <= 1'b1;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.op == dpbb_pkg::OP_LATCH) begin
      in_kind     <= kind;
      in_kf_clear <= no_leading_output && is_keyframe;
      in_discard  <= discard_prior;
      in_flush    <= flush_now;
      in_order    <= order_count;
      in_time     <= present_time;
      in_flags    <= {has_picture, wants_output, is_single_field};
      in_tag      <= picture_tag;
    end
    if (cand_v) begin
      pend_tag  <= cand_tag;
      pend_time <= cand_time;
      pend_drop <= cand_drop;
    end
    if ((cand_v || cmd.op == dpbb_pkg::OP_FLUSH) && pend_v) begin
      out_tag  <= pend_tag;
      out_time <= pend_time;
      dropped  <= pend_drop;
      last     <= !cand_v;
    end
    unique case (cmd.op)
      dpbb_pkg::OP_LAT_UPD: begin
        for (int k = 0; k < MAX_ENTRIES; k++) begin
          if ((CW'(k) < count) && in_flags[dpbb_pkg::FLAG_WANT]
              && e_flags[k][dpbb_pkg::FLAG_WANT] && (e_order[k] > in_order)
              && (e_lat[k] != 8'(dpbb_pkg::LAT_MAX))) begin
            e_lat[k] <= e_lat[k] + 8'd1;
          end
        end
      end
      dpbb_pkg::OP_REMOVE: begin
        for (int k = 0; k < MAX_ENTRIES - 1; k++) begin
          if (CW'(k) >= rm_at) begin
            e_order[k] <= e_order[k+1];
            e_time[k]  <= e_time[k+1];
            e_flags[k] <= e_flags[k+1];
            e_tag[k]   <= e_tag[k+1];
            e_lat[k]   <= e_lat[k+1];
          end
        end
      end
      dpbb_pkg::OP_INSERT: begin
        for (int k = 0; k < MAX_ENTRIES; k++) begin
          if (CW'(k) == idx) begin
            e_order[k] <= in_order;
            e_time[k]  <= in_time;
            e_flags[k] <= in_flags;
            e_tag[k]   <= in_tag;
            e_lat[k]   <= '0;
          end else if (k > 0 && CW'(k) > idx && CW'(k) <= count) begin
            e_order[k] <= e_order[k-1];
            e_time[k]  <= e_time[k-1];
            e_flags[k] <= e_flags[k-1];
            e_tag[k]   <= e_tag[k-1];
            e_lat[k]   <= e_lat[k-1];
          end
        end
      end
      default: begin
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ENTRIES))
    else $error("entry count above table depth");

  a_waiting_bound: assert property (@(posedge clk) disable iff (rst)
    waiting <= count)
    else $error("waiting count above entry count");

  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |=> !out_valid)
    else $error("result right after the final result of a transaction");

  a_no_remove_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.op == dpbb_pkg::OP_REMOVE |-> count != '0)
    else $error("removal from an empty table");

endmodule

[src/decoded_picture_buffer_bumping_unit.sv]
// Top level of the decoded picture buffer bumping unit: configuration
// registers and APB port. Depends on dpbb_pkg, dpbb_ctrl and dpbb_datapath.
//
//   channel   handshake                        payload
//   input     start && !busy                   kind .. flush_now
//   result    out_valid (one cycle, no stall)  out_tag, out_time, dropped, last
//   config    psel & penable & pwrite          paddr, pwdata
//
// An item keeps busy high after acceptance through its removals (one entry
// each cycle) and the sequential insertion search over the sorted table of
// up to MAX_ENTRIES entries. A keyframe that clears the buffer adds a scan
// over the kept entries and an emptying pass.
// A result appears in the cycle after the next result or the item's end is known.
// Reset clears the counters and the controller; the table needs no clearing.
// The receiver cannot stall; the last result is out in the first cycle with
// busy low.
`timescale 1ns / 1ps

module decoded_picture_buffer_bumping_unit #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               kind,
  input  logic signed [31:0] order_count,
  input  logic signed [63:0] present_time,
  input  logic               is_single_field,
  input  logic               wants_output,
  input  logic               has_picture,
  input  logic [15:0]        picture_tag,
  input  logic               no_leading_output,
  input  logic               is_keyframe,
  input  logic               discard_prior,
  input  logic               flush_now,
  output logic               out_valid,
  output logic [15:0]        out_tag,
  output logic signed [63:0] out_time,
  output logic               dropped,
  output logic               last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  dpbb_pkg::cfg_t    cfg;
  dpbb_pkg::cmd_t    cmd;
  dpbb_pkg::status_t st;
  logic [2:0]        reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.order_by_poc          <= 1'b1;
      cfg.two_fields_per_slot   <= 1'b0;
      cfg.max_pictures_buffered <= 5'd16;
      cfg.max_reorder_count     <= 5'd0;
      cfg.max_latency_count     <= 8'd0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        dpbb_pkg::REG_ORDER_BY_POC: cfg.order_by_poc          <= pwdata[0];
        dpbb_pkg::REG_TWO_FIELDS:   cfg.two_fields_per_slot   <= pwdata[0];
        dpbb_pkg::REG_MAX_PICS:     cfg.max_pictures_buffered <= pwdata[4:0];
        dpbb_pkg::REG_MAX_REORDER:  cfg.max_reorder_count     <= pwdata[4:0];
        dpbb_pkg::REG_MAX_LATENCY:  cfg.max_latency_count     <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      dpbb_pkg::REG_ORDER_BY_POC: prdata = 32'(cfg.order_by_poc);
      dpbb_pkg::REG_TWO_FIELDS:   prdata = 32'(cfg.two_fields_per_slot);
      dpbb_pkg::REG_MAX_PICS:     prdata = 32'(cfg.max_pictures_buffered);
      dpbb_pkg::REG_MAX_REORDER:  prdata = 32'(cfg.max_reorder_count);
      dpbb_pkg::REG_MAX_LATENCY:  prdata = 32'(cfg.max_latency_count);
      default:                    prdata = '0;
    endcase
  end

  dpbb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  dpbb_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .cmd               (cmd),
    .st                (st),
    .kind              (kind),
    .order_count       (order_count),
    .present_time      (present_time),
    .is_single_field   (is_single_field),
    .wants_output      (wants_output),
    .has_picture       (has_picture),
    .picture_tag       (picture_tag),
    .no_leading_output (no_leading_output),
    .is_keyframe       (is_keyframe),
    .discard_prior     (discard_prior),
    .flush_now         (flush_now),
    .out_valid         (out_valid),
    .out_tag           (out_tag),
    .out_time          (out_time),
    .dropped           (dropped),
    .last              (last)
  );

endmodule
